// ----- hw/rtl/uvs_pkg.sv -----
// Shared types, constants and functions of the UV-sphere vertex generator.
// Depends on nothing; used by uv_sphere_vertex_generator_core.
package uvs_pkg;

    localparam int MAX_RINGS    = 1024;
    localparam int MAX_SEGMENTS = 1024;
    localparam int MIN_RINGS    = 2;
    localparam int MIN_SEGMENTS = 3;

    localparam int CNT_W   = 11;
    localparam int IDX_W   = 21;
    localparam int TEX_W   = 17;
    localparam int ANG_W   = 24;
    localparam int DIV_W   = 25;
    localparam int REM_W   = 12;
    localparam int CX_W    = 34;
    localparam int Z_W     = 25;
    localparam int CORDIC_STEPS = 22;

    // Configuration register indexes.
    localparam logic [2:0] REG_RING_COUNT    = 3'd0;
    localparam logic [2:0] REG_SEGMENT_COUNT = 3'd1;
    localparam logic [2:0] REG_SPHERE_RADIUS = 3'd2;
    localparam logic [2:0] REG_CENTER_X      = 3'd3;
    localparam logic [2:0] REG_CENTER_Y      = 3'd4;
    localparam logic [2:0] REG_CENTER_Z      = 3'd5;

    // Pipeline stage numbers.
    localparam int ST_IN   = 0;
    localparam int ST_DIV0 = 1;
    localparam int ST_DIVN = ST_DIV0 + DIV_W - 1;
    localparam int ST_CSET = ST_DIVN + 1;
    localparam int ST_COR0 = ST_CSET + 1;
    localparam int ST_CORN = ST_COR0 + CORDIC_STEPS - 1;
    localparam int ST_FIX  = ST_CORN + 1;
    localparam int ST_M1   = ST_FIX + 1;
    localparam int ST_M2   = ST_M1 + 1;
    localparam int ST_M3   = ST_M2 + 1;
    localparam int ST_OUT  = ST_M3 + 1;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [CX_W-1:0] ONE_Q30         = 34'sd1073741824;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
        logic                   zero;
    } cord_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic [1:0]       tri_mask;
        logic [IDX_W-1:0] left_prev;
        logic [IDX_W-1:0] shared_top;
        logic [IDX_W-1:0] left_own;
        logic [IDX_W-1:0] right_own;
        logic [IDX_W-1:0] right_next_top;
    } topo_t;

    // Rotation angle of one CORDIC step, in Q0.24 turns.
    function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            0:  a = 25'sd2097152;
            1:  a = 25'sd1238021;
            2:  a = 25'sd654136;
            3:  a = 25'sd332050;
            4:  a = 25'sd166669;
            5:  a = 25'sd83416;
            6:  a = 25'sd41718;
            7:  a = 25'sd20860;
            8:  a = 25'sd10430;
            9:  a = 25'sd5215;
            10: a = 25'sd2608;
            11: a = 25'sd1304;
            12: a = 25'sd652;
            13: a = 25'sd326;
            14: a = 25'sd163;
            15: a = 25'sd81;
            16: a = 25'sd41;
            17: a = 25'sd20;
            18: a = 25'sd10;
            19: a = 25'sd5;
            20: a = 25'sd3;
            21: a = 25'sd1;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                  input int lo, input int hi);
        logic [CNT_W-1:0] r;
        if (v < CNT_W'(lo))
            r = CNT_W'(lo);
        else if (v > CNT_W'(hi))
            r = CNT_W'(hi);
        else
            r = v;
        return r;
    endfunction

    function automatic cord_t cord_init(input logic [ANG_W-1:0] ang);
        cord_t c;
        c.x    = CORDIC_GAIN_INV;
        c.y    = '0;
        c.z    = Z_W'($signed({3'b000, ang[21:0]}));
        c.quad = ang[23:22];
        c.zero = (ang[21:0] == 22'd0);
        return c;
    endfunction

    function automatic cord_t cord_step(input cord_t c, input int i);
        cord_t r;
        r = c;
        if (c.z >= 0)
        begin
            r.x = c.x - (c.y >>> i);
            r.y = c.y + (c.x >>> i);
            r.z = c.z - atan_turn(i);
        end
        else
        begin
            r.x = c.x + (c.y >>> i);
            r.y = c.y - (c.x >>> i);
            r.z = c.z + atan_turn(i);
        end
        return r;
    endfunction

    // Cosine in the upper half, sine in the lower half, both Q1.30.
    function automatic logic [2*32-1:0] cord_fix(input cord_t c);
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CX_W-1:0] co;
        logic signed [CX_W-1:0] si;
        x = c.zero ? ONE_Q30 : c.x;
        y = c.zero ? '0 : c.y;
        case (c.quad)
            2'd0:    begin co = x;  si = y;  end
            2'd1:    begin co = -y; si = x;  end
            2'd2:    begin co = -x; si = -y; end
            default: begin co = y;  si = -x; end
        endcase
        return {co[31:0], si[31:0]};
    endfunction

endpackage

// ----- hw/rtl/uv_sphere_vertex_generator_core.sv -----
// UV-sphere vertex generator: stream in a grid point, stream out its position,
// texture coordinates, vertex index and triangle indexes. Uses uvs_pkg.
module uv_sphere_vertex_generator_core
    import uvs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ring_step [10:0], segment_step [21:11]
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64], tex_u [112:96], tex_v [129:113],
    // vertex_index [150:130], tri_mask [152:151], left_prev [173:153],
    // shared_top [194:174], left_own [215:195], right_own [236:216],
    // right_next_top [257:237]
    output logic [263:0] m_tdata
);
    // The block takes one transaction per clock unless a result waits on the
    // output. Its pipeline holds a 25-stage restoring divider (one quotient
    // bit per stage) for the angles and texture coordinates, a 22-stage
    // CORDIC for sine and cosine, and four stages of multiply, round and
    // saturate. The whole pipeline holds while a result waits on the output;
    // no result is lost or repeated.

    logic [CNT_W-1:0]        ring_count_reg;
    logic [CNT_W-1:0]        segment_count_reg;
    logic [23:0]             sphere_radius_reg;
    logic signed [31:0]      center_x_reg;
    logic signed [31:0]      center_y_reg;
    logic signed [31:0]      center_z_reg;

    logic [CNT_W-1:0]        rings;
    logic [CNT_W-1:0]        segs;
    logic                    adv;

    logic                    vld_reg [ST_IN:ST_OUT];
    logic [CNT_W-1:0]        ring_reg;
    logic [CNT_W-1:0]        seg_reg;
    logic [CNT_W-1:0]        ring_next;
    logic [CNT_W-1:0]        seg_next;

    logic [REM_W-1:0]        rt_reg [ST_DIV0:ST_DIVN];
    logic [DIV_W-1:0]        qt_reg [ST_DIV0:ST_DIVN];
    logic [REM_W-1:0]        rr_reg [ST_DIV0:ST_DIVN];
    logic [DIV_W-1:0]        qr_reg [ST_DIV0:ST_DIVN];
    logic [REM_W-1:0]        rt_next [ST_DIV0:ST_DIVN];
    logic [DIV_W-1:0]        qt_next [ST_DIV0:ST_DIVN];
    logic [REM_W-1:0]        rr_next [ST_DIV0:ST_DIVN];
    logic [DIV_W-1:0]        qr_next [ST_DIV0:ST_DIVN];

    topo_t                   topo_reg [ST_DIV0:ST_OUT];
    topo_t                   topo_next;
    logic [TEX_W-1:0]        tex_u_reg [ST_CSET:ST_OUT];
    logic [TEX_W-1:0]        tex_v_reg [ST_CSET:ST_OUT];

    cord_t                   cph_reg [ST_CSET:ST_CORN];
    cord_t                   cth_reg [ST_CSET:ST_CORN];
    logic [ANG_W-1:0]        phi_ang;

    logic signed [31:0]      cp_reg;
    logic signed [31:0]      sp_reg;
    logic signed [31:0]      ct_reg;
    logic signed [31:0]      st_reg;
    logic [63:0]             fix_ph;
    logic [63:0]             fix_th;

    logic signed [63:0]      pa_reg;
    logic signed [63:0]      pb_reg;
    logic signed [31:0]      sp1_reg;
    logic signed [63:0]      pa_rnd;
    logic signed [63:0]      pb_rnd;
    logic signed [32:0]      ra_reg;
    logic signed [32:0]      rb_reg;
    logic signed [32:0]      sp2_reg;
    logic signed [57:0]      mx_reg;
    logic signed [57:0]      my_reg;
    logic signed [57:0]      mz_reg;
    logic signed [31:0]      px_next;
    logic signed [31:0]      py_next;
    logic signed [31:0]      pz_next;
    logic signed [31:0]      px_reg;
    logic signed [31:0]      py_reg;
    logic signed [31:0]      pz_reg;

    function automatic logic signed [31:0] place(input logic signed [57:0] m,
                                                 input logic signed [31:0] c);
        logic signed [57:0] t;
        logic signed [33:0] s;
        t = m + 58'sd536870912;
        s = 34'($signed(t[57:30])) + 34'(c);
        if (s > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= CNT_W'(16);
            segment_count_reg <= CNT_W'(32);
            sphere_radius_reg <= 24'd65536;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RING_COUNT:    ring_count_reg    <= cfg_wdata[CNT_W-1:0];
                REG_SEGMENT_COUNT: segment_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_wdata[23:0];
                REG_CENTER_X:      center_x_reg      <= cfg_wdata;
                REG_CENTER_Y:      center_y_reg      <= cfg_wdata;
                REG_CENTER_Z:      center_z_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign rings    = clamp_cnt(ring_count_reg, MIN_RINGS, MAX_RINGS);
    assign segs     = clamp_cnt(segment_count_reg, MIN_SEGMENTS, MAX_SEGMENTS);
    assign adv      = !vld_reg[ST_OUT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = ST_IN; i <= ST_OUT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[ST_IN] <= s_tvalid;
            for (int i = ST_IN + 1; i <= ST_OUT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb
    begin
        ring_next = (s_tdata[10:0] > rings) ? rings : s_tdata[10:0];
        seg_next  = (s_tdata[21:11] > segs) ? segs : s_tdata[21:11];
    end

    // Vertex index and triangle corners from the clamped grid point.
    always_comb
    begin
        logic [2*CNT_W-1:0] v;
        logic [IDX_W-1:0]   vi;
        logic [IDX_W-1:0]   top;
        v   = ring_reg * (segs + CNT_W'(1)) + (2*CNT_W)'(seg_reg);
        vi  = v[IDX_W-1:0];
        top = vi - IDX_W'(segs) - IDX_W'(1);
        topo_next = '0;
        topo_next.vertex_index = vi;
        if (ring_reg != '0)
        begin
            topo_next.shared_top = top;
            if (seg_reg != '0)
            begin
                topo_next.tri_mask[0] = 1'b1;
                topo_next.left_prev   = vi - IDX_W'(1);
                topo_next.left_own    = vi;
            end
            if (seg_reg != segs)
            begin
                topo_next.tri_mask[1]    = 1'b1;
                topo_next.right_own      = vi;
                topo_next.right_next_top = top + IDX_W'(1);
            end
        end
    end

    // Restoring division, one quotient bit per stage: q = floor(n * 2^24 / d).
    always_comb
    begin
        for (int i = ST_DIV0; i <= ST_DIVN; i++)
        begin
            logic [REM_W-1:0] tt;
            logic [REM_W-1:0] tr;
            logic [DIV_W-1:0] pqt;
            logic [DIV_W-1:0] pqr;
            if (i == ST_DIV0)
            begin
                tt  = REM_W'(seg_reg);
                tr  = REM_W'(ring_reg);
                pqt = '0;
                pqr = '0;
            end
            else
            begin
                tt  = {rt_reg[i-1][REM_W-2:0], 1'b0};
                tr  = {rr_reg[i-1][REM_W-2:0], 1'b0};
                pqt = qt_reg[i-1];
                pqr = qr_reg[i-1];
            end
            qt_next[i] = {pqt[DIV_W-2:0], tt >= REM_W'(segs)};
            rt_next[i] = (tt >= REM_W'(segs)) ? tt - REM_W'(segs) : tt;
            qr_next[i] = {pqr[DIV_W-2:0], tr >= REM_W'(rings)};
            rr_next[i] = (tr >= REM_W'(rings)) ? tr - REM_W'(rings) : tr;
        end
    end

    // phi = quarter turn minus ring / (2 * rings), modulo one turn.
    assign phi_ang = 24'h400000 - qr_reg[ST_DIVN][DIV_W-1:1];
    assign fix_ph  = cord_fix(cph_reg[ST_CORN]);
    assign fix_th  = cord_fix(cth_reg[ST_CORN]);
    assign pa_rnd  = pa_reg + 64'sd536870912;
    assign pb_rnd  = pb_reg + 64'sd536870912;
    assign px_next = place(mx_reg, center_x_reg);
    assign py_next = place(my_reg, center_y_reg);
    assign pz_next = place(mz_reg, center_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ring_reg <= ring_next;
            seg_reg  <= seg_next;

            topo_reg[ST_DIV0] <= topo_next;
            for (int i = ST_DIV0 + 1; i <= ST_OUT; i++)
                topo_reg[i] <= topo_reg[i-1];

            for (int i = ST_DIV0; i <= ST_DIVN; i++)
            begin
                rt_reg[i] <= rt_next[i];
                qt_reg[i] <= qt_next[i];
                rr_reg[i] <= rr_next[i];
                qr_reg[i] <= qr_next[i];
            end

            tex_u_reg[ST_CSET] <= qt_reg[ST_DIVN][DIV_W-1:8];
            tex_v_reg[ST_CSET] <= qr_reg[ST_DIVN][DIV_W-1:8];
            for (int i = ST_CSET + 1; i <= ST_OUT; i++)
            begin
                tex_u_reg[i] <= tex_u_reg[i-1];
                tex_v_reg[i] <= tex_v_reg[i-1];
            end

            cph_reg[ST_CSET] <= cord_init(phi_ang);
            cth_reg[ST_CSET] <= cord_init(qt_reg[ST_DIVN][ANG_W-1:0]);
            for (int i = ST_COR0; i <= ST_CORN; i++)
            begin
                cph_reg[i] <= cord_step(cph_reg[i-1], i - ST_COR0);
                cth_reg[i] <= cord_step(cth_reg[i-1], i - ST_COR0);
            end

            cp_reg <= fix_ph[63:32];
            sp_reg <= fix_ph[31:0];
            ct_reg <= fix_th[63:32];
            st_reg <= fix_th[31:0];

            pa_reg  <= 64'(cp_reg) * 64'(ct_reg);
            pb_reg  <= 64'(cp_reg) * 64'(st_reg);
            sp1_reg <= sp_reg;

            ra_reg  <= pa_rnd[62:30];
            rb_reg  <= pb_rnd[62:30];
            sp2_reg <= 33'(sp1_reg);

            mx_reg <= 58'($signed({1'b0, sphere_radius_reg})) * 58'(ra_reg);
            my_reg <= 58'($signed({1'b0, sphere_radius_reg})) * 58'(rb_reg);
            mz_reg <= 58'($signed({1'b0, sphere_radius_reg})) * 58'(sp2_reg);

            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    assign m_tdata = {6'd0,
                      topo_reg[ST_OUT].right_next_top,
                      topo_reg[ST_OUT].right_own,
                      topo_reg[ST_OUT].left_own,
                      topo_reg[ST_OUT].shared_top,
                      topo_reg[ST_OUT].left_prev,
                      topo_reg[ST_OUT].tri_mask,
                      topo_reg[ST_OUT].vertex_index,
                      tex_v_reg[ST_OUT],
                      tex_u_reg[ST_OUT],
                      pz_reg, py_reg, px_reg};

endmodule
